// ----- hdl/srdl_pkg.sv -----
// ----------------------------------------------------------------------------
// srdl_pkg
// Shared types and constants of the SPI response deframer with LRC check.
// ----------------------------------------------------------------------------
`default_nettype none

package srdl_pkg;

	// input function codes
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_BYTE  = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	// frame verdict codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_LRC     = 3'd1;
	localparam logic [2:0] ST_STATUS  = 3'd2;
	localparam logic [2:0] ST_TIMEOUT = 3'd3;
	localparam logic [2:0] ST_LONG    = 3'd4;

	// framing bytes
	localparam logic [7:0] START_BYTE = 8'h55;
	localparam logic [7:0] SW1_OK     = 8'h90;
	localparam logic [7:0] SW2_OK     = 8'h00;

	// timeout register reset value
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// one result item
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [12:0] byte_index;
		logic        frame_done;
		logic [2:0]  frame_status;
		logic [12:0] frame_length;
	} srdl_res_t;

endpackage

`default_nettype wire

// ----- hdl/srdl_if.sv -----
// ----------------------------------------------------------------------------
// srdl channel interfaces
// Valid/ready channels for input items, result items and the timeout register.
// ----------------------------------------------------------------------------
`default_nettype none

// input item channel
interface srdl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

// result item channel
interface srdl_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [12:0] byte_index;
	logic        frame_done;
	logic [2:0]  frame_status;
	logic [12:0] frame_length;

	modport source (output valid, output out_byte, output byte_index,
		output frame_done, output frame_status, output frame_length, input ready);
	modport sink   (input valid, input out_byte, input byte_index,
		input frame_done, input frame_status, input frame_length, output ready);
endinterface

// timeout register write channel
interface srdl_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] timeout_ms;

	modport source (output valid, output timeout_ms, input ready);
	modport sink   (input valid, input timeout_ms, output ready);
endinterface

`default_nettype wire

// ----- hdl/spi_response_deframer_lrc_unit.sv -----
// Pipeline: an input transfer is held in the input register, and its result
// is held in the result register. Throughput: one input item per cycle; the
// frame state update is combinational logic between the two registers.
// A held result stalls only items that themselves cause a result.
// Reset: arst_n clears both pipeline stages and the frame state to idle and
// loads timeout_ms with 1000.
// ----------------------------------------------------------------------------
// spi_response_deframer_lrc_unit
// Deframes a secure-element SPI response and checks its LRC byte.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_response_deframer_lrc_unit
	import srdl_pkg::*;
#(
	parameter int MAX_PAYLOAD = 4096
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	srdl_in_if.sink    req,
	srdl_out_if.source rsp,
	srdl_cfg_if.sink   cfg
);

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [7:0]  byte_s1;
	logic [15:0] timeout_q;
	logic        out_valid_q;
	srdl_res_t   out_q;
	logic        core_has_res;
	srdl_res_t   core_res;
	logic        out_free;
	logic        s1_go;

	// stage one advances unless its result cannot be stored
	assign out_free  = !out_valid_q || rsp.ready;
	assign s1_go     = valid_s1 && (!core_has_res || out_free);
	assign req.ready = !valid_s1 || s1_go;
	assign cfg.ready = 1'b1;

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			timeout_q <= cfg.timeout_ms;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			func_s1 <= req.func;
			byte_s1 <= req.rx_byte;
		end
	end

	srdl_core #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (s1_go),
		.func       (func_s1),
		.rx_byte    (byte_s1),
		.timeout_ms (timeout_q),
		.has_res    (core_has_res),
		.res        (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && core_has_res) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && core_has_res) begin
			out_q <= core_res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_byte     = out_q.out_byte;
	assign rsp.byte_index   = out_q.byte_index;
	assign rsp.frame_done   = out_q.frame_done;
	assign rsp.frame_status = out_q.frame_status;
	assign rsp.frame_length = out_q.frame_length;

`ifndef SYNTH
	// an input transfer always lands in stage one
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> valid_s1)
		else $error("input transfer lost before stage one");

	// a result that does not end the frame carries no verdict
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.frame_done) |-> (rsp.frame_status == ST_OK))
		else $error("verdict on a result that does not end the frame");

	// a length is reported only with an ok verdict
	a_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.frame_length != 13'd0) |->
		(rsp.frame_done && rsp.frame_status == ST_OK))
		else $error("frame length without ok verdict");
`endif

endmodule

`default_nettype wire

// ----- hdl/srdl_core.sv -----
// ----------------------------------------------------------------------------
// srdl_core
// Frame state machine: start hunt with timeout, header check, payload and LRC verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module srdl_core
	import srdl_pkg::*;
#(
	parameter int MAX_PAYLOAD = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [15:0] timeout_ms,
	output      logic        has_res,
	output      srdl_res_t   res
);

	localparam int CNT_NEED = $clog2(MAX_PAYLOAD + 5);
	localparam int CNT_W    = (CNT_NEED > 13) ? CNT_NEED : 13;
	localparam int CMP_W    = (CNT_W > 17) ? CNT_W : 17;

	typedef enum logic [1:0] {PH_IDLE, PH_HUNT, PH_HEADER, PH_BODY} phase_t;

	phase_t             phase_q, phase_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [15:0]        plen_q, plen_d;
	logic [7:0]         lrc_q, lrc_d;
	logic [15:0]        ms_q, ms_d;
	logic               sw_ok_q, sw_ok_d;

	logic [7:0]         lrc_x;
	logic [15:0]        plen_lo;
	logic [CMP_W-1:0]   body_end;
	logic [16:0]        frame_len;

	assign lrc_x     = lrc_q ^ rx_byte;
	assign plen_lo   = {plen_q[15:8], rx_byte};
	assign body_end  = CMP_W'(plen_q) + CMP_W'(4);
	assign frame_len = 17'(plen_q) + 17'd5;

	// next state and result for the item at hand
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		plen_d  = plen_q;
		lrc_d   = lrc_q;
		ms_d    = ms_q;
		sw_ok_d = sw_ok_q;
		has_res = 1'b0;
		res.out_byte     = rx_byte;
		res.byte_index   = cnt_q[12:0];
		res.frame_done   = 1'b0;
		res.frame_status = ST_OK;
		res.frame_length = 13'd0;
		case (func)
			FUNC_START: begin
				phase_d = PH_HUNT;
				cnt_d   = '0;
				plen_d  = '0;
				lrc_d   = '0;
				ms_d    = '0;
				sw_ok_d = 1'b0;
			end
			FUNC_TICK: begin
				if (phase_q == PH_HUNT) begin
					if (ms_q >= timeout_ms) begin
						phase_d          = PH_IDLE;
						has_res          = 1'b1;
						res.out_byte     = 8'd0;
						res.byte_index   = 13'd0;
						res.frame_done   = 1'b1;
						res.frame_status = ST_TIMEOUT;
					end else if (ms_q != 16'hFFFF) begin
						ms_d = ms_q + 16'd1;
					end
				end
			end
			FUNC_BYTE: begin
				case (phase_q)
					PH_HUNT: begin
						if (rx_byte == START_BYTE) begin
							phase_d = PH_HEADER;
							cnt_d   = '0;
							lrc_d   = '0;
							plen_d  = '0;
							sw_ok_d = 1'b0;
						end
					end
					PH_HEADER: begin
						lrc_d   = lrc_x;
						cnt_d   = cnt_q + CNT_W'(1);
						has_res = 1'b1;
						case (cnt_q[1:0])
							2'd0: sw_ok_d = (rx_byte == SW1_OK);
							2'd1: sw_ok_d = sw_ok_q && (rx_byte == SW2_OK);
							2'd2: plen_d  = {rx_byte, 8'd0};
							default: begin
								plen_d = plen_lo;
								// status checked before length
								if (!sw_ok_q) begin
									phase_d          = PH_IDLE;
									res.frame_done   = 1'b1;
									res.frame_status = ST_STATUS;
								end else if (17'(plen_lo) > 17'(MAX_PAYLOAD)) begin
									phase_d          = PH_IDLE;
									res.frame_done   = 1'b1;
									res.frame_status = ST_LONG;
								end else begin
									phase_d = PH_BODY;
								end
							end
						endcase
					end
					PH_BODY: begin
						has_res = 1'b1;
						if (CMP_W'(cnt_q) < body_end) begin
							lrc_d = lrc_x;
							cnt_d = cnt_q + CNT_W'(1);
						end else begin
							// last byte is the LRC
							phase_d        = PH_IDLE;
							res.frame_done = 1'b1;
							if (~lrc_q == rx_byte) begin
								res.frame_length = frame_len[12:0];
							end else begin
								res.frame_status = ST_LRC;
							end
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			plen_q  <= '0;
			lrc_q   <= '0;
			ms_q    <= '0;
			sw_ok_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			plen_q  <= plen_d;
			lrc_q   <= lrc_d;
			ms_q    <= ms_d;
			sw_ok_q <= sw_ok_d;
		end
	end

endmodule

`default_nettype wire

// ----- tb/spi_response_deframer_lrc_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_response_deframer_lrc_unit_tb
// Drives byte, tick and start transfers into the deframer and checks every
// result against a cycle-free frame predictor. It covers directed corner
// frames first, then random frames, noise and restarts. Timeout settings and
// idle patterns change between phases, and one long receiver stall backs up
// the block while a long frame streams in.
// ----------------------------------------------------------------------------

module spi_response_deframer_lrc_unit_tb;
	import srdl_pkg::*;

	localparam int MAX_PAYLOAD = 4096;
	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 20000;
	localparam int PHASE_ITEMS = 90;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// frame predictor and queue of expected results
	class deframer_scoreboard;
		typedef enum logic [1:0] {FR_IDLE, FR_HUNT, FR_HEADER, FR_BODY} frame_phase_t;

		frame_phase_t phase;
		int unsigned pos;
		int unsigned body_len;
		logic [7:0] lrc_acc;
		int unsigned ms_count;
		bit status_good;
		logic [15:0] timeout_limit;
		srdl_res_t expected_q[$];
		int errors;

		function new();
			phase = FR_IDLE;
			pos = 0;
			body_len = 0;
			lrc_acc = '0;
			ms_count = 0;
			status_good = 1'b0;
			timeout_limit = TIMEOUT_RESET;
			errors = 0;
		endfunction

		function void push_expected(logic [7:0] b, int unsigned idx, logic done,
				logic [2:0] st, int unsigned len);
			srdl_res_t r;
			r.out_byte = b;
			r.byte_index = idx[12:0];
			r.frame_done = done;
			r.frame_status = st;
			r.frame_length = len[12:0];
			expected_q.push_back(r);
		endfunction

		// advance the frame state by one accepted input transfer
		function void note_input(logic [1:0] func, logic [7:0] b);
			int unsigned idx;
			idx = pos;
			case (func)
			FUNC_START: begin
				phase = FR_HUNT;
				pos = 0;
				body_len = 0;
				lrc_acc = '0;
				ms_count = 0;
				status_good = 1'b0;
			end
			FUNC_TICK: begin
				if (phase == FR_HUNT) begin
					if (ms_count >= timeout_limit) begin
						phase = FR_IDLE;
						push_expected(8'd0, 0, 1'b1, ST_TIMEOUT, 0);
					end else if (ms_count < 16'hFFFF) begin
						ms_count++;
					end
				end
			end
			FUNC_BYTE: begin
				case (phase)
				FR_HUNT: begin
					if (b == START_BYTE) begin
						phase = FR_HEADER;
						pos = 0;
						lrc_acc = '0;
						body_len = 0;
						status_good = 1'b0;
					end
				end
				FR_HEADER: begin
					lrc_acc ^= b;
					pos++;
					case (idx)
					0: status_good = (b == SW1_OK);
					1: status_good = status_good && (b == SW2_OK);
					2: body_len = int'(b) << 8;
					default: begin
						body_len = body_len | int'(b);
						if (!status_good) begin
							phase = FR_IDLE;
							push_expected(b, idx, 1'b1, ST_STATUS, 0);
							return;
						end
						if (body_len > MAX_PAYLOAD) begin
							phase = FR_IDLE;
							push_expected(b, idx, 1'b1, ST_LONG, 0);
							return;
						end
						phase = FR_BODY;
					end
					endcase
					push_expected(b, idx, 1'b0, ST_OK, 0);
				end
				FR_BODY: begin
					if (idx < 4 + body_len) begin
						lrc_acc ^= b;
						pos++;
						push_expected(b, idx, 1'b0, ST_OK, 0);
					end else begin
						phase = FR_IDLE;
						if (~lrc_acc == b)
							push_expected(b, idx, 1'b1, ST_OK, 5 + body_len);
						else
							push_expected(b, idx, 1'b1, ST_LRC, 0);
					end
				end
				default: ;
				endcase
			end
			default: ;
			endcase
		endfunction

		// compare one result transfer with the oldest expectation
		function void check_result(srdl_res_t got);
			srdl_res_t exp_r;
			if (expected_q.size() == 0) begin
				$error("unexpected result: out_byte %0d byte_index %0d",
					got.out_byte, got.byte_index);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.out_byte !== exp_r.out_byte) begin
				$error("out_byte: expected %0d, got %0d", exp_r.out_byte, got.out_byte);
				errors++;
			end
			if (got.byte_index !== exp_r.byte_index) begin
				$error("byte_index: expected %0d, got %0d", exp_r.byte_index,
					got.byte_index);
				errors++;
			end
			if (got.frame_done !== exp_r.frame_done) begin
				$error("frame_done: expected %0d, got %0d", exp_r.frame_done,
					got.frame_done);
				errors++;
			end
			if (got.frame_status !== exp_r.frame_status) begin
				$error("frame_status: expected %0d, got %0d", exp_r.frame_status,
					got.frame_status);
				errors++;
			end
			if (got.frame_length !== exp_r.frame_length) begin
				$error("frame_length: expected %0d, got %0d", exp_r.frame_length,
					got.frame_length);
				errors++;
			end
		endfunction

		function void finish_check();
			if (expected_q.size() != 0) begin
				$error("%0d expected results never arrived", expected_q.size());
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	srdl_in_if  req_if();
	srdl_out_if rsp_if();
	srdl_cfg_if cfg_if();

	deframer_scoreboard sb = new();

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int items_sent;
	bit noisy;
	logic [15:0] cur_timeout;

	spi_response_deframer_lrc_unit #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// result side: check each transfer, then pick the next ready
	initial begin
		srdl_res_t got;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				got.out_byte = rsp_if.out_byte;
				got.byte_index = rsp_if.byte_index;
				got.frame_done = rsp_if.frame_done;
				got.frame_status = rsp_if.frame_status;
				got.frame_length = rsp_if.frame_length;
				sb.check_result(got);
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// one input transfer with random gaps in front
	task automatic send(logic [1:0] f, logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.func <= f;
		req_if.rx_byte <= b;
		do @(posedge clk); while (!req_if.ready);
		sb.note_input(f, b);
		if (f != FUNC_UNUSED)
			items_sent++;
	endtask

	// start, hunt noise, start byte, header, payload and lrc; cut stops early
	task automatic send_frame(logic [15:0] len, logic [7:0] sw1, logic [7:0] sw2,
			bit lrc_ok, int cut);
		logic [7:0] body[$];
		logic [7:0] x;
		logic [7:0] lrc;
		int ticks;
		int junk;
		send(FUNC_START, 8'($urandom));
		if (noisy) begin
			ticks = $urandom_range(0, (cur_timeout < 3) ? int'(cur_timeout) : 3);
			junk = $urandom_range(0, 2);
			while (ticks + junk > 0) begin
				if (junk == 0 || (ticks > 0 && $urandom_range(0, 1) == 0)) begin
					send(FUNC_TICK, 8'($urandom));
					ticks--;
				end else begin
					do x = 8'($urandom); while (x == START_BYTE);
					send(FUNC_BYTE, x);
					junk--;
				end
			end
		end
		send(FUNC_BYTE, START_BYTE);
		body = '{sw1, sw2, len[15:8], len[7:0]};
		if (sw1 == SW1_OK && sw2 == SW2_OK && len <= MAX_PAYLOAD) begin
			repeat (len) body.push_back(8'($urandom));
			lrc = '0;
			foreach (body[i]) lrc ^= body[i];
			x = ~lrc;
			if (!lrc_ok)
				x ^= 8'($urandom_range(1, 255));
			body.push_back(x);
		end
		foreach (body[i]) begin
			if (cut >= 0 && i >= cut)
				return;
			// ticks and unused codes past the hunt are ignored
			if (noisy && $urandom_range(0, 99) < 6)
				send($urandom_range(0, 1) ? FUNC_TICK : FUNC_UNUSED, 8'($urandom));
			send(FUNC_BYTE, body[i]);
		end
	endtask

	// wait until every expected result is back, then for the pipeline tail
	task automatic drain();
		int n;
		req_if.valid <= 1'b0;
		n = 0;
		while (sb.expected_q.size() != 0 && n < DRAIN_CYCLES) begin
			@(posedge clk);
			n++;
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_timeout(logic [15:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.timeout_ms <= v;
		do @(posedge clk); while (!cfg_if.ready);
		sb.timeout_limit = v;
		cur_timeout = v;
		cfg_if.valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		int pick;
		int target;
		int n;
		logic [15:0] plen;
		logic [7:0] sw1;
		logic [7:0] sw2;
		logic [15:0] phase_timeout[6];

		phase_timeout = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd40, 16'd12};
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.func <= FUNC_START;
		req_if.rx_byte <= 8'd0;
		rsp_if.ready <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.timeout_ms <= 16'd0;
		hold_left = 0;
		items_sent = 0;
		cur_timeout = TIMEOUT_RESET;
		send_idle_pct = 21;
		recv_idle_pct = 73;
		noisy = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle inputs and unused code, then corner frames
		send(FUNC_BYTE, 8'hFF);
		send(FUNC_TICK, 8'h00);
		send(FUNC_UNUSED, 8'hAA);
		send_frame(16'd0, SW1_OK, SW2_OK, 1'b1, -1);
		send_frame(16'd0, SW1_OK, SW2_OK, 1'b0, -1);
		// bad status wins over a too long length
		send_frame(16'hFFFF, 8'h91, SW2_OK, 1'b1, -1);
		send_frame(16'(MAX_PAYLOAD + 1), SW1_OK, SW2_OK, 1'b1, -1);
		// timeout at the reset setting
		send(FUNC_START, 8'h00);
		repeat (int'(cur_timeout) + 1) send(FUNC_TICK, 8'($urandom));

		// random phases with changing timeout and idle pattern
		noisy = 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_timeout(phase_timeout[ph]);
			send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 73 : 0;
			recv_idle_pct = (ph < 2) ? 73 : (ph < 4) ? 21 : 0;
			if (ph == 4) begin
				// long receiver stall while a long frame streams in
				hold_left = 400;
				send_frame(16'd120, SW1_OK, SW2_OK, 1'b1, -1);
			end
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				pick = $urandom_range(0, 99);
				if ($urandom_range(0, 9) == 0)
					plen = 16'($urandom_range(25, 300));
				else
					plen = 16'($urandom_range(0, 24));
				if (pick < 60) begin
					send_frame(plen, SW1_OK, SW2_OK, $urandom_range(0, 99) < 85, -1);
				end else if (pick < 70) begin
					sw1 = SW1_OK;
					sw2 = SW2_OK;
					case ($urandom_range(0, 2))
					0: sw1 = 8'($urandom);
					1: sw2 = 8'($urandom);
					default: begin
						sw1 = 8'($urandom);
						sw2 = 8'($urandom);
					end
					endcase
					send_frame(16'($urandom), sw1, sw2, 1'b1, -1);
				end else if (pick < 77) begin
					send_frame(16'($urandom_range(MAX_PAYLOAD + 1, 65535)), SW1_OK, SW2_OK,
						1'b1, -1);
				end else if (pick < 85 && cur_timeout <= 64) begin
					send(FUNC_START, 8'($urandom));
					repeat (int'(cur_timeout) + 1) send(FUNC_TICK, 8'($urandom));
				end else if (pick < 93) begin
					// frame dropped partway by the next start
					send_frame(plen, SW1_OK, SW2_OK, 1'b1, $urandom_range(0, 6));
				end else begin
					n = $urandom_range(1, 6);
					repeat (n) send(2'($urandom_range(0, 3)), 8'($urandom));
				end
				// stray bytes and ticks once the frame is over
				if ($urandom_range(0, 4) == 0)
					send(2'($urandom_range(1, 2)), 8'($urandom));
			end
		end

		drain();
		sb.finish_check();
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
